/* hw/rtl/vpa_pkg.sv */
`timescale 1ns / 1ps

package vpa_pkg;

    localparam int DATA_W        = 16;
    localparam int JOB_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int DEF_MAX_PARTS = 16;
    localparam int DEF_NUM_JOBS  = 16;
    localparam int DEF_ADDR_BITS = 16;

    localparam logic [DATA_W-1:0] RESET_TOTAL = 16'd640;
    localparam logic [DATA_W-1:0] HELD_MAX    = 16'hffff;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic [JOB_W-1:0]  owner;
        logic              used;
    } part_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_SCAN,
        CMD_DECIDE,
        CMD_SHIFT,
        CMD_APPLY,
        CMD_MERGE_INIT,
        CMD_MERGE,
        CMD_MERGE_END
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic zero;
        logic fail;
        logic split;
        logic shift_last;
        logic merge_single;
        logic merge_last;
    } stat_t;

endpackage

/* hw/rtl/vpa_if.sv */
`timescale 1ns / 1ps

interface vpa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [vpa_pkg::JOB_W-1:0]  job_id;
    logic [vpa_pkg::DATA_W-1:0] amount;
    modport source (output valid, op, job_id, amount, input ready);
    modport sink (input valid, op, job_id, amount, output ready);
endinterface

interface vpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [vpa_pkg::STATUS_W-1:0] status;
    logic [vpa_pkg::DATA_W-1:0]   location;
    logic [vpa_pkg::DATA_W-1:0]   held_total;
    modport source (output valid, status, location, held_total, input ready);
    modport sink (input valid, status, location, held_total, output ready);
endinterface

interface vpa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vpa_pkg::CFG_IDX_W-1:0] index;
    logic [vpa_pkg::DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/variable_partition_allocator_core.sv */
`timescale 1ns / 1ps

// Partition allocator. Requests arrive on req (op, job_id, amount) and each
// produces exactly one result on rsp (status, location, held_total). The
// cfg channel writes total_size (index 0, which rebuilds the table as one
// free partition) and fit_mode (index 1); it is always ready and should
// only be used while no request is in flight.
// A request walks the partition table one entry a cycle: a scan of up to
// part_count entries, a decide step, a shift pass when a split opens a new
// slot, an apply step and a merge pass over the table; a zero amount or a
// failed request goes from the decide step straight to the result. One
// request is handled at a time; req.ready is low until the result transfer
// has completed and rises in the cycle after it. If the receiver stalls,
// the result is held on rsp until taken.
// Reset leaves one free partition of 640 units, first fit, and every
// job total at zero.
module variable_partition_allocator_core #(
    parameter int MAX_PARTS = vpa_pkg::DEF_MAX_PARTS,
    parameter int NUM_JOBS  = vpa_pkg::DEF_NUM_JOBS,
    parameter int ADDR_BITS = vpa_pkg::DEF_ADDR_BITS
) (
    input  logic   clk,
    input  logic   rst_n,
    vpa_req_if.sink   req,
    vpa_rsp_if.source rsp,
    vpa_cfg_if.sink   cfg
);

    vpa_pkg::cmd_t  cmd;
    vpa_pkg::stat_t stat;

    assign cfg.ready = 1'b1;

    vpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    vpa_datapath #(
        .MAX_PARTS (MAX_PARTS),
        .NUM_JOBS  (NUM_JOBS),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (req.op),
        .job_id     (req.job_id),
        .amount     (req.amount),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .status     (rsp.status),
        .location   (rsp.location),
        .held_total (rsp.held_total)
    );

endmodule

/* hw/rtl/vpa_ctrl.sv */
`timescale 1ns / 1ps

module vpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  vpa_pkg::stat_t     stat,
    output vpa_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_APPLY,
        S_MINIT,
        S_MERGE,
        S_MEND,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   valid_reg;

    assign req_ready = ready_reg;
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = vpa_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd        = vpa_pkg::CMD_ACCEPT;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd = vpa_pkg::CMD_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd = vpa_pkg::CMD_DECIDE;
                if (stat.zero || stat.fail)
                begin
                    state_next = S_RESP;
                end
                else if (stat.split)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_SHIFT:
            begin
                cmd = vpa_pkg::CMD_SHIFT;
                if (stat.shift_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd        = vpa_pkg::CMD_APPLY;
                state_next = S_MINIT;
            end
            S_MINIT:
            begin
                cmd        = vpa_pkg::CMD_MERGE_INIT;
                state_next = stat.merge_single ? S_MEND : S_MERGE;
            end
            S_MERGE:
            begin
                cmd = vpa_pkg::CMD_MERGE;
                if (stat.merge_last)
                begin
                    state_next = S_MEND;
                end
            end
            S_MEND:
            begin
                cmd        = vpa_pkg::CMD_MERGE_END;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
            valid_reg <= (state_next == S_RESP);
        end
    end

endmodule

/* hw/rtl/vpa_datapath.sv */
`timescale 1ns / 1ps

module vpa_datapath #(
    parameter int MAX_PARTS = vpa_pkg::DEF_MAX_PARTS,
    parameter int NUM_JOBS  = vpa_pkg::DEF_NUM_JOBS,
    parameter int ADDR_BITS = vpa_pkg::DEF_ADDR_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vpa_pkg::cmd_t                   cmd,
    output vpa_pkg::stat_t                  stat,
    input  logic                            op,
    input  logic [vpa_pkg::JOB_W-1:0]       job_id,
    input  logic [vpa_pkg::DATA_W-1:0]      amount,
    input  logic                            cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vpa_pkg::DATA_W-1:0]      cfg_data,
    output logic [vpa_pkg::STATUS_W-1:0]    status,
    output logic [vpa_pkg::DATA_W-1:0]      location,
    output logic [vpa_pkg::DATA_W-1:0]      held_total
);

    localparam int DW    = vpa_pkg::DATA_W;
    localparam int IDXW  = $clog2(MAX_PARTS);
    localparam int CNTW  = $clog2(MAX_PARTS + 1);
    localparam int HIDXW = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam logic [DW-1:0] LOC_MASK =
        (ADDR_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << ADDR_BITS) - 64'd1);

    vpa_pkg::part_t tab_reg [MAX_PARTS];
    logic [DW-1:0]  held_reg [NUM_JOBS];

    logic                        op_reg;
    logic [vpa_pkg::JOB_W-1:0]   job_reg;
    logic [DW-1:0]               amt_reg;
    logic [CNTW-1:0]             i_reg;
    logic                        found_reg;
    logic [IDXW-1:0]             sel_reg;
    logic [DW-1:0]               sel_len_reg;
    logic [DW-1:0]               sel_start_reg;
    logic [IDXW-1:0]             k_reg;
    logic [IDXW-1:0]             w_reg;
    logic [CNTW-1:0]             r_reg;
    vpa_pkg::part_t              wbuf_reg;
    logic [CNTW-1:0]             count_reg;
    logic                        mode_reg;
    logic [vpa_pkg::STATUS_W-1:0] status_reg;
    logic [DW-1:0]               loc_reg;
    logic [DW-1:0]               held_out_reg;

    logic [IDXW-1:0]  rd_idx;
    vpa_pkg::part_t   rd;
    logic             hit;
    logic             take;
    logic             tracked;
    logic [HIDXW-1:0] hidx;
    logic [DW-1:0]    held_cur;
    logic [DW:0]      held_sum;
    logic [DW-1:0]    held_new;
    logic             full;
    logic             wr_en;
    logic [IDXW-1:0]  wr_idx;
    vpa_pkg::part_t   wr_data;

    assign status     = status_reg;
    assign location   = loc_reg;
    assign held_total = held_out_reg;

    always_comb
    begin
        case (cmd)
            vpa_pkg::CMD_SCAN:  rd_idx = i_reg[IDXW-1:0];
            vpa_pkg::CMD_SHIFT: rd_idx = k_reg - IDXW'(1);
            vpa_pkg::CMD_MERGE: rd_idx = r_reg[IDXW-1:0];
            default:            rd_idx = '0;
        endcase
    end

    assign rd = tab_reg[rd_idx];

    always_comb
    begin
        if (op_reg == vpa_pkg::OP_FREE)
        begin
            hit = rd.used && (rd.owner == job_reg) && (rd.length >= amt_reg);
        end
        else
        begin
            hit = !rd.used && (rd.length >= amt_reg);
        end
    end

    // Best fit keeps the earliest of equal lengths, so only a strictly shorter one replaces it.
    assign take = hit && (!found_reg ||
                  (mode_reg && (op_reg == vpa_pkg::OP_ALLOC) && (rd.length < sel_len_reg)));

    assign tracked  = (32'(job_reg) < NUM_JOBS);
    assign hidx     = HIDXW'(job_reg);
    assign held_cur = tracked ? held_reg[hidx] : '0;
    assign held_sum = {1'b0, held_cur} + {1'b0, amt_reg};

    always_comb
    begin
        if (op_reg == vpa_pkg::OP_FREE)
        begin
            held_new = (held_cur > amt_reg) ? (held_cur - amt_reg) : '0;
        end
        else
        begin
            held_new = held_sum[DW] ? vpa_pkg::HELD_MAX : held_sum[DW-1:0];
        end
    end

    assign full = (sel_len_reg > amt_reg) && (32'(count_reg) >= MAX_PARTS);

    always_comb
    begin
        stat.scan_last    = ((32'(i_reg) + 1) >= 32'(count_reg)) ||
                            (take && ((op_reg == vpa_pkg::OP_FREE) || !mode_reg));
        stat.zero         = (amt_reg == '0);
        stat.fail         = !found_reg || full;
        stat.split        = (sel_len_reg > amt_reg);
        stat.shift_last   = (k_reg == sel_reg + IDXW'(1));
        stat.merge_single = (count_reg == CNTW'(1));
        stat.merge_last   = ((32'(r_reg) + 1) >= 32'(count_reg));
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = rd;
        case (cmd)
            vpa_pkg::CMD_NONE:
            begin
                if (cfg_we && (cfg_index == vpa_pkg::REG_TOTAL_SIZE))
                begin
                    wr_en   = 1'b1;
                    wr_data = '{start: '0, length: cfg_data, owner: '0, used: 1'b0};
                end
            end
            vpa_pkg::CMD_SHIFT:
            begin
                wr_en  = 1'b1;
                wr_idx = k_reg;
                if (k_reg == sel_reg + IDXW'(1))
                begin
                    // The remainder stays with the side it came from.
                    wr_data.start  = sel_start_reg + amt_reg;
                    wr_data.length = sel_len_reg - amt_reg;
                    wr_data.owner  = (op_reg == vpa_pkg::OP_FREE) ? job_reg : '0;
                    wr_data.used   = (op_reg == vpa_pkg::OP_FREE);
                end
            end
            vpa_pkg::CMD_APPLY:
            begin
                wr_en          = 1'b1;
                wr_idx         = sel_reg;
                wr_data.start  = sel_start_reg;
                wr_data.length = amt_reg;
                wr_data.owner  = (op_reg == vpa_pkg::OP_FREE) ? '0 : job_reg;
                wr_data.used   = (op_reg == vpa_pkg::OP_ALLOC);
            end
            vpa_pkg::CMD_MERGE:
            begin
                if (wbuf_reg.used || rd.used)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = w_reg;
                    wr_data = wbuf_reg;
                end
            end
            vpa_pkg::CMD_MERGE_END:
            begin
                wr_en   = 1'b1;
                wr_idx  = w_reg;
                wr_data = wbuf_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < MAX_PARTS; n++)
            begin
                tab_reg[n] <= '0;
            end
            tab_reg[0].length <= vpa_pkg::RESET_TOTAL;
            for (int n = 0; n < NUM_JOBS; n++)
            begin
                held_reg[n] <= '0;
            end
            count_reg <= CNTW'(1);
            mode_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                tab_reg[wr_idx] <= wr_data;
            end
            if (cmd == vpa_pkg::CMD_NONE && cfg_we)
            begin
                case (cfg_index)
                    vpa_pkg::REG_TOTAL_SIZE: count_reg <= CNTW'(1);
                    vpa_pkg::REG_FIT_MODE:   mode_reg  <= cfg_data[0];
                    default:                 mode_reg  <= mode_reg;
                endcase
            end
            if (cmd == vpa_pkg::CMD_SHIFT && stat.shift_last)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            if (cmd == vpa_pkg::CMD_APPLY && tracked)
            begin
                held_reg[hidx] <= held_new;
            end
            if (cmd == vpa_pkg::CMD_MERGE_END)
            begin
                count_reg <= CNTW'(w_reg) + CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            vpa_pkg::CMD_ACCEPT:
            begin
                op_reg    <= op;
                job_reg   <= job_id;
                amt_reg   <= amount;
                i_reg     <= '0;
                found_reg <= 1'b0;
            end
            vpa_pkg::CMD_SCAN:
            begin
                i_reg <= i_reg + CNTW'(1);
                if (take)
                begin
                    found_reg     <= 1'b1;
                    sel_reg       <= i_reg[IDXW-1:0];
                    sel_len_reg   <= rd.length;
                    sel_start_reg <= rd.start;
                end
            end
            vpa_pkg::CMD_DECIDE:
            begin
                k_reg        <= count_reg[IDXW-1:0];
                loc_reg      <= '0;
                held_out_reg <= held_cur;
                if (!found_reg)
                begin
                    status_reg <= (op_reg == vpa_pkg::OP_FREE) ? vpa_pkg::ST_NOMATCH
                                                               : vpa_pkg::ST_NOFIT;
                end
                else if (full)
                begin
                    status_reg <= vpa_pkg::ST_FULL;
                end
                else
                begin
                    status_reg <= vpa_pkg::ST_OK;
                end
                if (amt_reg == '0)
                begin
                    status_reg <= vpa_pkg::ST_OK;
                end
            end
            vpa_pkg::CMD_SHIFT:
            begin
                k_reg <= k_reg - IDXW'(1);
            end
            vpa_pkg::CMD_APPLY:
            begin
                status_reg   <= vpa_pkg::ST_OK;
                loc_reg      <= sel_start_reg & LOC_MASK;
                held_out_reg <= tracked ? held_new : '0;
            end
            vpa_pkg::CMD_MERGE_INIT:
            begin
                wbuf_reg <= rd;
                w_reg    <= '0;
                r_reg    <= CNTW'(1);
            end
            vpa_pkg::CMD_MERGE:
            begin
                r_reg <= r_reg + CNTW'(1);
                if (!wbuf_reg.used && !rd.used)
                begin
                    wbuf_reg.length <= wbuf_reg.length + rd.length;
                end
                else
                begin
                    w_reg    <= w_reg + IDXW'(1);
                    wbuf_reg <= rd;
                end
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

endmodule

/* hw/rtl/vpa_checker.sv */
`timescale 1ns / 1ps

module vpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [vpa_pkg::STATUS_W-1:0] status,
    input logic [vpa_pkg::DATA_W-1:0]   location
);

    // A pending result must wait until the receiver takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before its transfer");

    // Requests are taken only when no result is outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request accepted while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready && !rsp_valid)
        else $error("block not busy after accepting a request");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != vpa_pkg::ST_OK) |-> (location == '0))
        else $error("failed request reports a nonzero location");

endmodule

bind variable_partition_allocator_core vpa_checker u_vpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .location  (rsp.location)
);

/* test/variable_partition_allocator_core_tb.sv */
`timescale 1ns / 1ps

module variable_partition_allocator_core_tb;

    localparam int PARTS = vpa_pkg::DEF_MAX_PARTS;
    localparam int JOBS  = vpa_pkg::DEF_NUM_JOBS;

    typedef struct packed {
        logic                       op;
        logic [vpa_pkg::JOB_W-1:0]  job_id;
        logic [vpa_pkg::DATA_W-1:0] amount;
    } req_item_t;

    typedef struct packed {
        logic [vpa_pkg::STATUS_W-1:0] status;
        logic [vpa_pkg::DATA_W-1:0]   location;
        logic [vpa_pkg::DATA_W-1:0]   held_total;
    } outcome_t;

    logic clk;
    logic rst_n;

    vpa_req_if req ();
    vpa_rsp_if rsp ();
    vpa_cfg_if cfg ();

    variable_partition_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // Predicted allocator state.
    logic [vpa_pkg::DATA_W-1:0] mem_size;
    logic                       best_fit;
    vpa_pkg::part_t             tbl [PARTS];
    int                         tbl_count;
    logic [vpa_pkg::DATA_W-1:0] held [JOBS];

    req_item_t pending_reqs [$];
    outcome_t  expected_outcomes [$];
    int        errors;
    bit        send_hold;
    bit        long_stall;
    bit        long_stall_go;
    int        burst_left;
    int        gap_left;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void rebuild_table();
        for (int i = 0; i < PARTS; i++)
        begin
            tbl[i] = '0;
        end
        tbl[0].length = mem_size;
        tbl_count = 1;
    endfunction

    function automatic void merge_free_parts();
        int w;
        w = 0;
        for (int r = 1; r < tbl_count; r++)
        begin
            if (!tbl[w].used && !tbl[r].used)
            begin
                tbl[w].length = tbl[w].length + tbl[r].length;
            end
            else
            begin
                w++;
                tbl[w] = tbl[r];
            end
        end
        for (int r = w + 1; r < tbl_count; r++)
        begin
            tbl[r] = '0;
        end
        tbl_count = w + 1;
    endfunction

    // Splits entry sel at amt; the upper part takes the given owner and used bit.
    function automatic void split_part(int sel, logic [vpa_pkg::DATA_W-1:0] amt,
                                       logic [vpa_pkg::JOB_W-1:0] own, logic used);
        for (int k = tbl_count; k > sel + 1; k--)
        begin
            tbl[k] = tbl[k-1];
        end
        tbl_count++;
        tbl[sel+1].start  = tbl[sel].start + amt;
        tbl[sel+1].length = tbl[sel].length - amt;
        tbl[sel+1].owner  = own;
        tbl[sel+1].used   = used;
    endfunction

    function automatic outcome_t serve_request(req_item_t r);
        outcome_t o;
        int sel;
        int held_sum;
        o = '0;
        o.status = vpa_pkg::ST_OK;
        sel = -1;
        if (r.amount != 0)
        begin
            if (r.op == vpa_pkg::OP_ALLOC)
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!tbl[i].used && tbl[i].length >= r.amount)
                    begin
                        if (sel < 0 || (best_fit && tbl[i].length < tbl[sel].length))
                        begin
                            sel = i;
                            if (!best_fit)
                            begin
                                break;
                            end
                        end
                    end
                end
                if (sel < 0)
                begin
                    o.status = vpa_pkg::ST_NOFIT;
                end
                else if (tbl[sel].length > r.amount && tbl_count >= PARTS)
                begin
                    o.status = vpa_pkg::ST_FULL;
                end
                else
                begin
                    o.location = tbl[sel].start;
                    if (tbl[sel].length > r.amount)
                    begin
                        split_part(sel, r.amount, '0, 1'b0);
                    end
                    tbl[sel].length = r.amount;
                    tbl[sel].owner  = r.job_id;
                    tbl[sel].used   = 1'b1;
                    held_sum = held[r.job_id] + r.amount;
                    held[r.job_id] = (held_sum > vpa_pkg::HELD_MAX) ?
                                     vpa_pkg::HELD_MAX : held_sum[vpa_pkg::DATA_W-1:0];
                end
            end
            else
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl[i].used && tbl[i].owner == r.job_id && tbl[i].length >= r.amount)
                    begin
                        sel = i;
                        break;
                    end
                end
                if (sel < 0)
                begin
                    o.status = vpa_pkg::ST_NOMATCH;
                end
                else if (tbl[sel].length > r.amount && tbl_count >= PARTS)
                begin
                    o.status = vpa_pkg::ST_FULL;
                end
                else
                begin
                    o.location = tbl[sel].start;
                    if (tbl[sel].length > r.amount)
                    begin
                        split_part(sel, r.amount, r.job_id, 1'b1);
                    end
                    tbl[sel].length = r.amount;
                    tbl[sel].owner  = '0;
                    tbl[sel].used   = 1'b0;
                    held[r.job_id] = (held[r.job_id] > r.amount) ?
                                     held[r.job_id] - r.amount : '0;
                end
            end
            merge_free_parts();
        end
        o.held_total = held[r.job_id];
        return o;
    endfunction

    function automatic req_item_t make_req(logic op, int job, int amt);
        req_item_t r;
        r.op = op;
        r.job_id = job[vpa_pkg::JOB_W-1:0];
        r.amount = amt[vpa_pkg::DATA_W-1:0];
        return r;
    endfunction

    function automatic void queue_req(req_item_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3 * PARTS + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [vpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [vpa_pkg::DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        if (idx == vpa_pkg::REG_TOTAL_SIZE)
        begin
            mem_size = val;
            rebuild_table();
        end
        else
        begin
            best_fit = val[0];
        end
        @(posedge clk);
    endtask

    // Mostly small amounts so that the table fills and splits often.
    function automatic req_item_t random_req();
        int amt;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            amt = $urandom_range(1, 60);
        end
        else if (pick < 17)
        begin
            amt = $urandom_range(1, 400);
        end
        else if (pick < 19)
        begin
            amt = $urandom_range(0, 65535);
        end
        else
        begin
            amt = 0;
        end
        return make_req($urandom_range(0, 1), $urandom_range(0, 15), amt);
    endfunction

    // Driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            req.op     <= 1'b0;
            req.job_id <= '0;
            req.amount <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_outcomes.insert(expected_outcomes.size(),
                                         serve_request(pending_reqs.pop_front()));
            end
            if (req.valid && !req.ready)
            begin
                // Hold the offered item until it is taken.
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (send_hold || pending_reqs.size() == 0)
            begin
                req.valid <= 1'b0;
            end
            else
            begin
                req_item_t nxt;
                nxt = pending_reqs[0];
                req.valid  <= 1'b1;
                req.op     <= nxt.op;
                req.job_id <= nxt.job_id;
                req.amount <= nxt.amount;
                if (burst_left > 0)
                begin
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: expected no result, actual status=%0d location=%0d held=%0d",
                             $time, rsp.status, rsp.location, rsp.held_total);
                    errors++;
                end
                else
                begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, rsp.status);
                        errors++;
                    end
                    if (rsp.location !== e.location)
                    begin
                        $display("%0t: location expected %0d actual %0d",
                                 $time, e.location, rsp.location);
                        errors++;
                    end
                    if (rsp.held_total !== e.held_total)
                    begin
                        $display("%0t: held_total expected %0d actual %0d",
                                 $time, e.held_total, rsp.held_total);
                        errors++;
                    end
                end
            end
            if (long_stall)
            begin
                rsp.ready <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1: rsp.ready <= 1'b0;
                    default: rsp.ready <= 1'b1;
                endcase
            end
        end
    end

    // Long receiver stall, counted here once requested.
    initial
    begin
        wait (long_stall_go);
        long_stall = 1'b1;
        repeat (400) @(posedge clk);
        long_stall = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("variable_partition_allocator_core_tb: errors");
        $finish;
    end

    initial
    begin
        errors = 0;
        send_hold = 1'b0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = vpa_pkg::REG_TOTAL_SIZE;
        cfg.data = '0;
        mem_size = vpa_pkg::RESET_TOTAL;
        best_fit = 1'b0;
        rebuild_table();
        for (int j = 0; j < JOBS; j++)
        begin
            held[j] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero amount, exact fit, splits, frees, no match, no fit.
        queue_req(make_req(vpa_pkg::OP_ALLOC, 0, 0));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 15, 100));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 1, 540));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 2, 1));
        queue_req(make_req(vpa_pkg::OP_FREE, 15, 40));
        queue_req(make_req(vpa_pkg::OP_FREE, 3, 1));
        queue_req(make_req(vpa_pkg::OP_FREE, 1, 540));
        queue_req(make_req(vpa_pkg::OP_FREE, 15, 65535));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 4, 65535));
        queue_req(make_req(vpa_pkg::OP_FREE, 15, 60));
        wait_drained();

        // Fill the table with single units to reach the table full case.
        write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'd20);
        for (int i = 0; i < 17; i++)
        begin
            queue_req(make_req(vpa_pkg::OP_ALLOC, i % 16, 1));
        end
        queue_req(make_req(vpa_pkg::OP_FREE, 0, 1));
        wait_drained();

        // Largest memory, best fit, saturating totals.
        write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'hffff);
        write_reg(vpa_pkg::REG_FIT_MODE, 16'd1);
        queue_req(make_req(vpa_pkg::OP_ALLOC, 7, 65535));
        queue_req(make_req(vpa_pkg::OP_FREE, 7, 65535));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 7, 30000));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 7, 35535));
        queue_req(make_req(vpa_pkg::OP_ALLOC, 8, 1));
        wait_drained();

        // Zero memory: nothing fits.
        write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'd0);
        queue_req(make_req(vpa_pkg::OP_ALLOC, 9, 1));
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'd640);
                1: write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'd1);
                2: write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'd300);
                3: write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'hffff);
                default: write_reg(vpa_pkg::REG_TOTAL_SIZE, 16'($urandom_range(50, 2000)));
            endcase
            write_reg(vpa_pkg::REG_FIT_MODE, {15'd0, phase[0]});
            for (int n = 0; n < 155; n++)
            begin
                queue_req(random_req());
            end
            if (phase == 2)
            begin
                // Hold off the receiver while requests keep arriving.
                long_stall_go = 1'b1;
            end
            if (phase == 4)
            begin
                repeat (300) @(posedge clk);
                send_hold = 1'b1;
                while (expected_outcomes.size() != 0 || req.valid)
                begin
                    @(posedge clk);
                end
                repeat (20) @(posedge clk);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("variable_partition_allocator_core_tb: clean");
        end
        else
        begin
            $display("variable_partition_allocator_core_tb: errors");
        end
        $finish;
    end
endmodule
